// ----- rtl/core/kcac_pkg.sv -----
package kcac_pkg;

	localparam int NUM_BUTTONS_DEFAULT = 4;
	localparam int MAX_BUTTONS         = 7;
	localparam int INPUT_BUTTONS       = 4;

	localparam int DIGIT_W  = 3;
	localparam int CODE_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int HIST_W   = 8;
	localparam int TAKEN_W  = 3;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 4;

	localparam logic [HIST_W-1:0] PRESS_MASK    = 8'hDF;
	localparam logic [HIST_W-1:0] PRESS_PATTERN = 8'h07;
	localparam logic [HIST_W-1:0] HIST_RESET    = 8'hFF;

	localparam logic [COUNT_W-1:0] ARM_DELAY_RESET     = 8'd10;
	localparam logic [COUNT_W-1:0] PRESCALE_CMP_RESET  = 8'd50;
	localparam logic [COUNT_W-1:0] ENTRY_TIMEOUT_RESET = 8'd200;
	localparam logic [CODE_W-1:0]  CODE_MASK_RESET     = 16'h02A3;

	typedef enum logic [1:0] {
		REG_ARM_DELAY     = 2'd0,
		REG_PRESCALE_CMP  = 2'd1,
		REG_ENTRY_TIMEOUT = 2'd2,
		REG_CODE_MASK     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic                armed;
		logic                arming_on;
		logic [COUNT_W-1:0]  seconds_left;
		logic [CODE_W-1:0]   code_buffer;
		logic [TAKEN_W-1:0]  digits_taken;
		logic                alarm_off;
		logic                armed_now;
	} result_t;

endpackage

// ----- rtl/core/keypad_code_arming_controller_core.sv -----
// keypad code arming controller
// one request on the btn channel per poll tick carries the four button levels;
// each request yields exactly one result on the res channel (armed flags,
// countdown, code buffer, digit count and the alarm_off / armed_now pulses)
// channels use valid/ready; a request is taken when btn_valid and btn_ready
// are both high, a result is taken when res_valid and res_ready are high
// the result is registered, in the result register or, when the receiver stalls, in the skid
// throughput: one request per cycle while btn_ready is high; the whole tick update
// is one short combinational pass over the buttons between the state registers
// and the result register
// a stalled receiver is absorbed by a one-entry skid behind the result
// register, so one more request is taken while a result waits; btn_ready
// drops only when both hold a result
// the apb port writes the four setup registers (byte address 4*index) and
// reads them back; write only while no request is in flight
// reset (arst_n low) restores the register defaults and the tick state:
// histories all ones, code and flags clear, countdown ten, timers at one
module keypad_code_arming_controller_core #(
	parameter int NUM_BUTTONS = kcac_pkg::NUM_BUTTONS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kcac_pkg::APB_AW-1:0]  paddr,
	input  logic [kcac_pkg::APB_DW-1:0]  pwdata,
	output logic [kcac_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         btn_valid,
	output logic                         btn_ready,
	input  logic                         button_one,
	input  logic                         button_two,
	input  logic                         button_three,
	input  logic                         button_four,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         armed,
	output logic                         arming_on,
	output logic [kcac_pkg::COUNT_W-1:0] seconds_left,
	output logic [kcac_pkg::CODE_W-1:0]  code_buffer,
	output logic [kcac_pkg::TAKEN_W-1:0] digits_taken,
	output logic                         alarm_off,
	output logic                         armed_now
);

	localparam int CW = kcac_pkg::COUNT_W;
	localparam int KW = kcac_pkg::CODE_W;
	localparam int HW = kcac_pkg::HIST_W;
	localparam int DW = kcac_pkg::DIGIT_W;

	// setup registers
	logic [CW-1:0] arm_delay_q;
	logic [CW-1:0] prescale_cmp_q;
	logic [CW-1:0] entry_timeout_q;
	logic [KW-1:0] code_mask_q;

	// tick state
	logic [HW-1:0] hist_q [NUM_BUTTONS];
	logic [KW-1:0] code_q;
	logic          arming_q;
	logic [CW-1:0] countdown_q;
	logic [CW-1:0] prescale_q;
	logic [CW-1:0] entry_timer_q;
	logic          armed_q;

	// next state
	logic [HW-1:0] hist_d [NUM_BUTTONS];
	logic [KW-1:0] code_d;
	logic          arming_d;
	logic [CW-1:0] countdown_d;
	logic [CW-1:0] prescale_d;
	logic [CW-1:0] entry_timer_d;
	logic          armed_d;
	kcac_pkg::result_t result_d;

	// output register and skid
	kcac_pkg::result_t res_q;
	kcac_pkg::result_t skid_q;
	logic              skid_valid_q;

	logic [kcac_pkg::MAX_BUTTONS-1:0] levels;
	logic                             accept;
	logic                             cfg_write;
	kcac_pkg::reg_index_t             reg_sel;

	assign pready    = 1'b1;
	assign reg_sel   = kcac_pkg::reg_index_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_delay_q     <= kcac_pkg::ARM_DELAY_RESET;
			prescale_cmp_q  <= kcac_pkg::PRESCALE_CMP_RESET;
			entry_timeout_q <= kcac_pkg::ENTRY_TIMEOUT_RESET;
			code_mask_q     <= kcac_pkg::CODE_MASK_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				kcac_pkg::REG_ARM_DELAY:     arm_delay_q     <= pwdata[CW-1:0];
				kcac_pkg::REG_PRESCALE_CMP:  prescale_cmp_q  <= pwdata[CW-1:0];
				kcac_pkg::REG_ENTRY_TIMEOUT: entry_timeout_q <= pwdata[CW-1:0];
				kcac_pkg::REG_CODE_MASK:     code_mask_q     <= pwdata[KW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			kcac_pkg::REG_ARM_DELAY:     prdata = {(kcac_pkg::APB_DW-CW)'(0), arm_delay_q};
			kcac_pkg::REG_PRESCALE_CMP:  prdata = {(kcac_pkg::APB_DW-CW)'(0), prescale_cmp_q};
			kcac_pkg::REG_ENTRY_TIMEOUT: prdata = {(kcac_pkg::APB_DW-CW)'(0), entry_timeout_q};
			kcac_pkg::REG_CODE_MASK:     prdata = {(kcac_pkg::APB_DW-KW)'(0), code_mask_q};
			default:                     prdata = '0;
		endcase
	end

	// buttons past the four inputs always sample low
	assign levels = {(kcac_pkg::MAX_BUTTONS-kcac_pkg::INPUT_BUTTONS)'(0),
		button_four, button_three, button_two, button_one};

	always_comb begin
		logic [KW-1:0]                code;
		logic [CW-1:0]                timer;
		logic [CW-1:0]                presc;
		logic [CW-1:0]                cd;
		logic                         arming;
		logic                         armd;
		logic                         aoff;
		logic                         anow;
		logic [kcac_pkg::TAKEN_W-1:0] taken;
		logic [HW-1:0]                hist;

		code   = code_q;
		timer  = entry_timer_q;
		presc  = prescale_q;
		cd     = countdown_q;
		arming = arming_q;
		armd   = armed_q;
		aoff   = 1'b0;
		anow   = 1'b0;
		taken  = '0;

		// stale partial code is dropped before this tick's presses
		if (entry_timer_q >= entry_timeout_q) begin
			code  = '0;
			timer = CW'(1);
		end

		for (int b = 0; b < NUM_BUTTONS; b++) begin
			hist      = {hist_q[b][HW-2:0], levels[b]};
			hist_d[b] = hist;
			if ((hist & kcac_pkg::PRESS_MASK) == kcac_pkg::PRESS_PATTERN) begin
				code  = {code[KW-DW-1:0], DW'(b + 1)};
				timer = CW'(1);
				taken = taken + kcac_pkg::TAKEN_W'(1);
				if ((code & code_mask_q) == code_mask_q) begin
					code   = '0;
					presc  = CW'(1);
					arming = !arming;
					if (!arming) begin
						cd   = arm_delay_q;
						armd = 1'b0;
						aoff = 1'b1;
					end
				end
			end
		end

		// one second passes each time the prescaler, counting ticks up from one, reaches prescale_cmp_q
		if (arming && cd != '0) begin
			presc = presc + CW'(1);
			if (presc == prescale_cmp_q) begin
				cd = cd - CW'(1);
				if (cd == '0) begin
					armd = 1'b1;
					anow = 1'b1;
				end
				presc = CW'(1);
			end
		end

		code_d        = code;
		entry_timer_d = timer + CW'(1);
		prescale_d    = presc;
		countdown_d   = cd;
		arming_d      = arming;
		armed_d       = armd;

		result_d.armed        = armd;
		result_d.arming_on    = arming;
		result_d.seconds_left = cd;
		result_d.code_buffer  = code;
		result_d.digits_taken = taken;
		result_d.alarm_off    = aoff;
		result_d.armed_now    = anow;
	end

	assign btn_ready = !skid_valid_q;
	assign accept    = btn_valid && btn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				hist_q[b] <= kcac_pkg::HIST_RESET;
			end
			code_q        <= '0;
			arming_q      <= 1'b0;
			countdown_q   <= kcac_pkg::ARM_DELAY_RESET;
			prescale_q    <= CW'(1);
			entry_timer_q <= CW'(1);
			armed_q       <= 1'b0;
		end else if (accept) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				hist_q[b] <= hist_d[b];
			end
			code_q        <= code_d;
			arming_q      <= arming_d;
			countdown_q   <= countdown_d;
			prescale_q    <= prescale_d;
			entry_timer_q <= entry_timer_d;
			armed_q       <= armed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid || res_ready) begin
			// skid drains first; a request is only taken while the skid is empty
			if (skid_valid_q) begin
				res_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid || res_ready) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (accept) begin
				res_q <= result_d;
			end
		end else if (accept) begin
			skid_q <= result_d;
		end
	end

	assign armed        = res_q.armed;
	assign arming_on    = res_q.arming_on;
	assign seconds_left = res_q.seconds_left;
	assign code_buffer  = res_q.code_buffer;
	assign digits_taken = res_q.digits_taken;
	assign alarm_off    = res_q.alarm_off;
	assign armed_now    = res_q.armed_now;

endmodule

// ----- rtl/core/kcac_checker.sv -----
module kcac_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         btn_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         armed,
	input logic                         arming_on,
	input logic [kcac_pkg::COUNT_W-1:0] seconds_left,
	input logic [kcac_pkg::CODE_W-1:0]  code_buffer,
	input logic [kcac_pkg::TAKEN_W-1:0] digits_taken,
	input logic                         alarm_off,
	input logic                         armed_now
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(armed) && $stable(arming_on)
			&& $stable(seconds_left) && $stable(code_buffer) && $stable(digits_taken)
			&& $stable(alarm_off) && $stable(armed_now))
		else $error("stalled result changed");

	// back pressure only when the result register is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!btn_ready |-> res_valid)
		else $error("request stalled with no result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && armed_now |-> armed && arming_on)
		else $error("armed pulse without armed state");

	// armed only once the countdown is spent and arming is still on
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && armed |-> arming_on && seconds_left == '0)
		else $error("armed with countdown running or arming off");

endmodule

bind keypad_code_arming_controller_core kcac_checker u_kcac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.btn_ready    (btn_ready),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.armed        (armed),
	.arming_on    (arming_on),
	.seconds_left (seconds_left),
	.code_buffer  (code_buffer),
	.digits_taken (digits_taken),
	.alarm_off    (alarm_off),
	.armed_now    (armed_now)
);
